/* rtl/core/mi4_pkg.sv */
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared widths, types and index helpers for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

	localparam int ELEM_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int COF_MAG_W = 3 * ELEM_W;
	localparam int COF_ACC_W = COF_MAG_W + 2;
	localparam int DET_MAG_W = 4 * ELEM_W + 1;
	localparam int DET_ACC_W = DET_MAG_W + 1;
	localparam int NUM_W     = COF_MAG_W + 2 * FRAC_W;
	localparam int QUO_W     = ELEM_W + 1;
	localparam int DSH_W     = DET_MAG_W + QUO_W;
	localparam int DIV_W     = (NUM_W > DSH_W) ? NUM_W : DSH_W;

	localparam logic [3:0] LAST_IDX  = 4'd15;
	localparam logic [2:0] LAST_PERM = 3'd5;
	localparam logic [1:0] LAST_LIMB = 2'd2;
	localparam logic [1:0] LAST_ROW  = 2'd3;

	typedef struct packed {
		logic              we;
		logic [3:0]        addr;
		logic [ELEM_W-1:0] data;
	} elem_wr_t;

	typedef struct packed {
		logic [ELEM_W-1:0] value;
		logic              last;
		logic              sing;
		logic              sat;
	} result_t;

	// Index k (0..2) of the rows or columns that remain when one is removed.
	function automatic logic [1:0] minor_idx(input logic [1:0] skip, input logic [1:0] k);
		return (k < skip) ? k : 2'(k + 2'd1);
	endfunction

	// Column picked by factor f in permutation p of the 3x3 Leibniz expansion.
	function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] f);
		logic [5:0] row;
		unique case (p)
			3'd0: row = {2'd2, 2'd1, 2'd0};
			3'd1: row = {2'd0, 2'd2, 2'd1};
			3'd2: row = {2'd1, 2'd0, 2'd2};
			3'd3: row = {2'd1, 2'd2, 2'd0};
			3'd4: row = {2'd2, 2'd0, 2'd1};
			3'd5: row = {2'd0, 2'd1, 2'd2};
			default: row = {2'd2, 2'd1, 2'd0};
		endcase
		return row[{f, 1'b0} +: 2];
	endfunction

	function automatic logic perm_odd(input logic [2:0] p);
		return (p >= 3'd3);
	endfunction

	function automatic logic [ELEM_W-1:0] mag_of(input logic [ELEM_W-1:0] v);
		return v[ELEM_W-1] ? ELEM_W'(~v + 1'b1) : v;
	endfunction

endpackage

/* rtl/core/mi4_divider.sv */
// ----------------------------------------------------------------------------
// mi4_divider
// Restoring divider, one quotient bit per cycle, with round half away from
// zero and saturation to the signed element range.
// ----------------------------------------------------------------------------
module mi4_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mi4_pkg::COF_MAG_W-1:0] num_mag,
	input  logic [mi4_pkg::DET_MAG_W-1:0] den_mag,
	input  logic                          neg,
	output logic                          done,
	output logic [mi4_pkg::ELEM_W-1:0]    value,
	output logic                          sat
);

	localparam int CNT_W = $clog2(mi4_pkg::QUO_W);
	localparam logic [mi4_pkg::ELEM_W-1:0] MAX_VAL = {1'b0, {(mi4_pkg::ELEM_W-1){1'b1}}};
	localparam logic [mi4_pkg::ELEM_W-1:0] MIN_VAL = {1'b1, {(mi4_pkg::ELEM_W-1){1'b0}}};
	localparam logic [mi4_pkg::QUO_W:0] LIM =
		(mi4_pkg::QUO_W+1)'(1) << (mi4_pkg::ELEM_W-1);

	typedef enum logic [1:0] {D_IDLE, D_CHK, D_STEP, D_RND} dstate_t;

	dstate_t                    state_q;
	logic [mi4_pkg::DIV_W-1:0]  rem_q;
	logic [mi4_pkg::DIV_W-1:0]  dsh_q;
	logic [mi4_pkg::QUO_W-1:0]  q_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       neg_q;
	logic                       done_q;
	logic                       sat_q;
	logic [mi4_pkg::ELEM_W-1:0] value_q;

	logic [mi4_pkg::DIV_W-1:0]  dsh_half;
	logic                       step_ge;
	logic                       rnd_bit;
	logic [mi4_pkg::QUO_W:0]    q_rnd;

	assign dsh_half = dsh_q >> 1;
	assign step_ge  = (rem_q >= dsh_half);
	assign rnd_bit  = ((rem_q << 1) >= dsh_q);
	assign q_rnd    = {1'b0, q_q} + {{mi4_pkg::QUO_W{1'b0}}, rnd_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						rem_q   <= mi4_pkg::DIV_W'({num_mag, {(2*mi4_pkg::FRAC_W){1'b0}}});
						dsh_q   <= mi4_pkg::DIV_W'({den_mag, {mi4_pkg::QUO_W{1'b0}}});
						neg_q   <= neg;
						q_q     <= '0;
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					// A quotient that needs more bits than the loop makes is clamped.
					if (rem_q >= dsh_q) begin
						value_q <= neg_q ? MIN_VAL : MAX_VAL;
						sat_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						cnt_q   <= CNT_W'(mi4_pkg::QUO_W - 1);
						state_q <= D_STEP;
					end
				end
				D_STEP: begin
					rem_q <= step_ge ? (rem_q - dsh_half) : rem_q;
					q_q   <= {q_q[mi4_pkg::QUO_W-2:0], step_ge};
					dsh_q <= dsh_half;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= D_RND;
					end
				end
				D_RND: begin
					if (neg_q) begin
						sat_q   <= (q_rnd > LIM);
						value_q <= (q_rnd > LIM) ? MIN_VAL :
							mi4_pkg::ELEM_W'(~q_rnd[mi4_pkg::ELEM_W-1:0] + 1'b1);
					end else begin
						sat_q   <= (q_rnd >= LIM);
						value_q <= (q_rnd >= LIM) ? MAX_VAL : q_rnd[mi4_pkg::ELEM_W-1:0];
					end
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign value = value_q;
	assign sat   = sat_q;

endmodule

/* rtl/core/mi4_engine.sv */
// ----------------------------------------------------------------------------
// mi4_engine
// Element memory, cofactor memory and the sequencer that forms cofactors and
// the determinant on one shared multiplier and the sixteen quotients in the divider.
// ----------------------------------------------------------------------------
module mi4_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  mi4_pkg::elem_wr_t wr,
	input  logic              start,
	output logic              busy,
	output logic              res_valid,
	input  logic              res_ready,
	output mi4_pkg::result_t  res
);

	localparam int E = mi4_pkg::ELEM_W;

	typedef enum logic [4:0] {
		S_IDLE, S_TA, S_TB, S_TC, S_M1, S_M2, S_M3, S_ACC, S_WR,
		S_DRD, S_DCAP, S_DMUL, S_DACC, S_DFIN,
		S_ORD, S_OCAP, S_OWAIT, S_OEMIT
	} state_t;

	logic [E-1:0]                    mat_mem [16];
	logic [E-1:0]                    mat_rdata_q;
	logic [3:0]                      mat_raddr;
	logic [mi4_pkg::COF_MAG_W:0]     cof_mem [16];
	logic [mi4_pkg::COF_MAG_W:0]     cof_rdata_q;
	logic [3:0]                      cof_raddr;
	logic                            cof_we;
	logic [mi4_pkg::COF_MAG_W:0]     cof_wdata;

	state_t                          state_q;
	logic [3:0]                      cof_idx_q;
	logic [2:0]                      perm_q;
	logic [1:0]                      k_q;
	logic [1:0]                      limb_q;
	logic [3:0]                      out_idx_q;
	logic [E-1:0]                    a_mag_q;
	logic [E-1:0]                    c_mag_q;
	logic                            sign_q;
	logic [2*E-1:0]                  mul_q;
	logic [2*E-1:0]                  p1_q;
	logic [2*E-1:0]                  lo_q;
	logic [mi4_pkg::COF_ACC_W-1:0]   acc_q;
	logic [mi4_pkg::COF_MAG_W-1:0]   cofm_q;
	logic [mi4_pkg::DET_ACC_W-1:0]   det_q;
	logic                            det_sign_q;
	logic [mi4_pkg::DET_MAG_W-1:0]   det_mag_q;
	logic                            sing_q;
	logic [E-1:0]                    val_q;
	logic                            sat_q;

	logic [1:0]                      fac;
	logic [1:0]                      row_sel;
	logic [1:0]                      col_sel;
	logic [E-1:0]                    mul_x;
	logic [E-1:0]                    mul_y;
	logic [2*E-1:0]                  mul_p;
	logic [3*E-1:0]                  term;
	logic [mi4_pkg::COF_ACC_W-1:0]   acc_next;
	logic [mi4_pkg::COF_ACC_W-1:0]   acc_abs;
	logic                            cof_flip;
	logic [4*E-1:0]                  det_term;
	logic [mi4_pkg::DET_ACC_W-1:0]   det_ext;
	logic [mi4_pkg::DET_ACC_W-1:0]   det_abs;
	logic                            div_start;
	logic                            div_done;
	logic [E-1:0]                    div_value;
	logic                            div_sat;

	// Element address of factor fac of the current term.
	always_comb begin
		unique case (state_q)
			S_TB:    fac = 2'd1;
			S_TC:    fac = 2'd2;
			default: fac = 2'd0;
		endcase
		row_sel = mi4_pkg::minor_idx(cof_idx_q[3:2], fac);
		col_sel = mi4_pkg::minor_idx(cof_idx_q[1:0], mi4_pkg::perm_col(perm_q, fac));
	end

	always_comb begin
		unique case (state_q)
			S_TA, S_TB, S_TC: mat_raddr = {row_sel, col_sel};
			S_DRD:            mat_raddr = {2'b00, k_q};
			default:          mat_raddr = '0;
		endcase
		unique case (state_q)
			S_DRD:   cof_raddr = {2'b00, k_q};
			S_ORD:   cof_raddr = {out_idx_q[1:0], out_idx_q[3:2]};
			default: cof_raddr = '0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_TC: begin
				mul_x = a_mag_q;
				mul_y = mi4_pkg::mag_of(mat_rdata_q);
			end
			S_M2: begin
				mul_x = p1_q[E-1:0];
				mul_y = c_mag_q;
			end
			S_M3: begin
				mul_x = p1_q[2*E-1:E];
				mul_y = c_mag_q;
			end
			S_DMUL: begin
				mul_x = a_mag_q;
				unique case (limb_q)
					2'd0:    mul_y = cofm_q[E-1:0];
					2'd1:    mul_y = cofm_q[2*E-1:E];
					default: mul_y = cofm_q[3*E-1:2*E];
				endcase
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign mul_p    = mul_x * mul_y;
	assign term     = {mul_q, {E{1'b0}}} + {{E{1'b0}}, lo_q};
	assign acc_next = sign_q ? (acc_q - mi4_pkg::COF_ACC_W'(term))
	                         : (acc_q + mi4_pkg::COF_ACC_W'(term));
	assign acc_abs  = acc_q[mi4_pkg::COF_ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign cof_flip = cof_idx_q[2] ^ cof_idx_q[0];
	assign cof_we   = (state_q == S_WR);
	assign cof_wdata = {acc_q[mi4_pkg::COF_ACC_W-1] ^ cof_flip,
	                    acc_abs[mi4_pkg::COF_MAG_W-1:0]};

	always_comb begin
		unique case (limb_q)
			2'd0:    det_term = (4*E)'(mul_q);
			2'd1:    det_term = (4*E)'({mul_q, {E{1'b0}}});
			default: det_term = {mul_q, {(2*E){1'b0}}};
		endcase
		det_ext = mi4_pkg::DET_ACC_W'(det_term);
	end

	assign det_abs   = det_q[mi4_pkg::DET_ACC_W-1] ? (~det_q + 1'b1) : det_q;
	assign div_start = (state_q == S_OCAP) && !sing_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mat_mem[wr.addr] <= wr.data;
		end
		mat_rdata_q <= mat_mem[mat_raddr];
	end

	always_ff @(posedge clk) begin
		if (cof_we) begin
			cof_mem[cof_idx_q] <= cof_wdata;
		end
		cof_rdata_q <= cof_mem[cof_raddr];
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cof_idx_q <= '0;
			perm_q    <= '0;
			k_q       <= '0;
			limb_q    <= '0;
			out_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cof_idx_q <= '0;
						perm_q    <= '0;
						acc_q     <= '0;
						state_q   <= S_TA;
					end
				end
				S_TA: state_q <= S_TB;
				S_TB: begin
					a_mag_q <= mi4_pkg::mag_of(mat_rdata_q);
					sign_q  <= mat_rdata_q[E-1] ^ mi4_pkg::perm_odd(perm_q);
					state_q <= S_TC;
				end
				S_TC: begin
					sign_q  <= sign_q ^ mat_rdata_q[E-1];
					state_q <= S_M1;
				end
				S_M1: begin
					c_mag_q <= mi4_pkg::mag_of(mat_rdata_q);
					sign_q  <= sign_q ^ mat_rdata_q[E-1];
					p1_q    <= mul_q;
					state_q <= S_M2;
				end
				S_M2: state_q <= S_M3;
				S_M3: begin
					lo_q    <= mul_q;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_next;
					if (perm_q == mi4_pkg::LAST_PERM) begin
						perm_q  <= '0;
						state_q <= S_WR;
					end else begin
						perm_q  <= perm_q + 1'b1;
						state_q <= S_TA;
					end
				end
				S_WR: begin
					acc_q     <= '0;
					cof_idx_q <= cof_idx_q + 1'b1;
					if (cof_idx_q == mi4_pkg::LAST_IDX) begin
						k_q     <= '0;
						det_q   <= '0;
						state_q <= S_DRD;
					end else begin
						state_q <= S_TA;
					end
				end
				S_DRD: state_q <= S_DCAP;
				S_DCAP: begin
					a_mag_q <= mi4_pkg::mag_of(mat_rdata_q);
					cofm_q  <= cof_rdata_q[mi4_pkg::COF_MAG_W-1:0];
					sign_q  <= mat_rdata_q[E-1] ^ cof_rdata_q[mi4_pkg::COF_MAG_W];
					limb_q  <= '0;
					state_q <= S_DMUL;
				end
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					det_q <= sign_q ? (det_q - det_ext) : (det_q + det_ext);
					if (limb_q == mi4_pkg::LAST_LIMB) begin
						if (k_q == mi4_pkg::LAST_ROW) begin
							state_q <= S_DFIN;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_DRD;
						end
					end else begin
						limb_q  <= limb_q + 1'b1;
						state_q <= S_DMUL;
					end
				end
				S_DFIN: begin
					det_sign_q <= det_q[mi4_pkg::DET_ACC_W-1];
					det_mag_q  <= det_abs[mi4_pkg::DET_MAG_W-1:0];
					sing_q     <= (det_q == '0);
					out_idx_q  <= '0;
					state_q    <= S_ORD;
				end
				S_ORD: state_q <= S_OCAP;
				S_OCAP: begin
					if (sing_q) begin
						val_q   <= '0;
						sat_q   <= 1'b0;
						state_q <= S_OEMIT;
					end else begin
						state_q <= S_OWAIT;
					end
				end
				S_OWAIT: begin
					if (div_done) begin
						val_q   <= div_value;
						sat_q   <= div_sat;
						state_q <= S_OEMIT;
					end
				end
				S_OEMIT: begin
					if (res_ready) begin
						out_idx_q <= out_idx_q + 1'b1;
						state_q   <= (out_idx_q == mi4_pkg::LAST_IDX) ? S_IDLE : S_ORD;
					end
				end
			endcase
		end
	end

	mi4_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (cof_rdata_q[mi4_pkg::COF_MAG_W-1:0]),
		.den_mag (det_mag_q),
		.neg     (cof_rdata_q[mi4_pkg::COF_MAG_W] ^ det_sign_q),
		.done    (div_done),
		.value   (div_value),
		.sat     (div_sat)
	);

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OEMIT);
	assign res.value = val_q;
	assign res.last  = (out_idx_q == mi4_pkg::LAST_IDX);
	assign res.sing  = sing_q;
	assign res.sat   = sat_q;

endmodule

/* rtl/core/matrix_inverse_4x4.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// Inverse of a 4x4 signed fixed-point matrix by cofactors.
//
//   channel   direction  payload                                handshake
//   element   in         element_value                          valid / stall
//   inverse   out        inverse_value, is_last, singular,      valid / stall
//                        saturated
//
// Elements 1 to 15 of a matrix are taken one per cycle. After the sixteenth,
// element_stall stays high while the engine forms 96 three-factor terms on
// the one multiplier, then the determinant, then each result in the
// bit-serial divider, and while the output stalls. Reset clears the load
// count and all sequencers; the memories hold no reset value.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       element_valid,
	output logic                       element_stall,
	input  logic [mi4_pkg::ELEM_W-1:0] element_value,
	output logic                       inverse_valid,
	input  logic                       inverse_stall,
	output logic [mi4_pkg::ELEM_W-1:0] inverse_value,
	output logic                       is_last,
	output logic                       singular,
	output logic                       saturated
);

	logic              [3:0] load_cnt_q;
	logic                    accept;
	logic                    start;
	logic                    busy;
	logic                    res_valid;
	logic                    res_ready;
	mi4_pkg::elem_wr_t       wr;
	mi4_pkg::result_t        res;
	logic                    out_valid_q;
	mi4_pkg::result_t        out_q;

	assign element_stall = busy;
	assign accept        = element_valid && !element_stall;
	assign start         = accept && (load_cnt_q == mi4_pkg::LAST_IDX);
	assign wr.we         = accept;
	assign wr.addr       = load_cnt_q;
	assign wr.data       = element_value;
	assign res_ready     = !out_valid_q || !inverse_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (accept) begin
			load_cnt_q <= load_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (!inverse_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	mi4_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.start     (start),
		.busy      (busy),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign inverse_valid = out_valid_q;
	assign inverse_value = out_q.value;
	assign is_last       = out_q.last;
	assign singular      = out_q.sing;
	assign saturated     = out_q.sat;

`ifndef SYNTH
	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (load_cnt_q == '0))
		else $error("load count moved while the engine was busy");

	a_busy_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("engine started without a full matrix");

	a_singular_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.sing) |-> (!out_q.sat && (out_q.value == '0)))
		else $error("singular result carries a value or a clamp flag");
`endif

endmodule

/* sim/matrix_inverse_4x4_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_tb
// Streams whole 4x4 matrices into the cofactor inverse block and checks every
// inverse element and flag against an exact wide-integer prediction. Identity,
// singular and saturating matrices come first, then random matrices of mixed
// kinds, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_tb;

	typedef logic signed [255:0] wide_t;

	localparam logic [mi4_pkg::ELEM_W-1:0] ONE_Q   = 32'h0001_0000;
	localparam logic [mi4_pkg::ELEM_W-1:0] MAX_Q   = 32'h7FFF_FFFF;
	localparam logic [mi4_pkg::ELEM_W-1:0] MIN_Q   = 32'h8000_0000;
	localparam int                         MATRICES = 28;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       element_valid = 1'b0;
	logic                       element_stall;
	logic [mi4_pkg::ELEM_W-1:0] element_value = '0;
	logic                       inverse_valid;
	logic                       inverse_stall = 1'b0;
	logic [mi4_pkg::ELEM_W-1:0] inverse_value;
	logic                       is_last, singular, saturated;

	logic [mi4_pkg::ELEM_W-1:0]        pending_elements[$];
	mi4_pkg::result_t                  expected_inverse[$];
	logic signed [mi4_pkg::ELEM_W-1:0] loaded_matrix[16];
	int                                load_index = 0;
	int                                send_idle = 0, recv_idle = 0, error_count = 0;
	logic [mi4_pkg::ELEM_W-1:0]        mat[16];

	always #5 clk = ~clk;

	matrix_inverse_4x4 i_dut (.*);

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		error_count++;
	endtask

	function automatic wide_t elem(input int r, input int c);
		wide_t x;
		x = loaded_matrix[r * 4 + c];
		return x;
	endfunction

	// Signed cofactor of the element at row sr, column sc.
	function automatic wide_t cofactor(input int sr, input int sc);
		int    rw[3], cl[3];
		int    n, m;
		wide_t d;
		n = 0;
		m = 0;
		for (int i = 0; i < 4; i++) begin
			if (i != sr) rw[n++] = i;
			if (i != sc) cl[m++] = i;
		end
		d = elem(rw[0], cl[0]) * (elem(rw[1], cl[1]) * elem(rw[2], cl[2])
				- elem(rw[1], cl[2]) * elem(rw[2], cl[1]))
			- elem(rw[0], cl[1]) * (elem(rw[1], cl[0]) * elem(rw[2], cl[2])
				- elem(rw[1], cl[2]) * elem(rw[2], cl[0]))
			+ elem(rw[0], cl[2]) * (elem(rw[1], cl[0]) * elem(rw[2], cl[1])
				- elem(rw[1], cl[1]) * elem(rw[2], cl[0]));
		return ((sr + sc) % 2) ? -d : d;
	endfunction

	task automatic predict_inverse();
		wide_t            cof[16];
		wide_t            det, dmag, nmag, quot, lim;
		logic             neg;
		mi4_pkg::result_t r;
		det = 0;
		for (int k = 0; k < 16; k++) cof[k] = cofactor(k / 4, k % 4);
		for (int k = 0; k < 4; k++) det = det + elem(0, k) * cof[k];
		dmag = (det < 0) ? -det : det;
		lim = wide_t'(1) <<< (mi4_pkg::ELEM_W - 1);
		for (int k = 0; k < 16; k++) begin
			r = '0;
			r.last = (k == 15);
			r.sing = (det == 0);
			if (det != 0) begin
				// Transposed cofactor; round half away from zero on the magnitude.
				nmag = cof[(k % 4) * 4 + k / 4];
				neg = (nmag < 0) != (det < 0);
				if (nmag < 0) nmag = -nmag;
				nmag = nmag <<< (2 * mi4_pkg::FRAC_W);
				quot = (2 * nmag + dmag) / (2 * dmag);
				if (neg) begin
					if (quot > lim) begin
						quot = lim;
						r.sat = 1'b1;
					end
					r.value = mi4_pkg::ELEM_W'(-quot);
				end else begin
					if (quot > lim - 1) begin
						quot = lim - 1;
						r.sat = 1'b1;
					end
					r.value = mi4_pkg::ELEM_W'(quot);
				end
			end
			expected_inverse.push_back(r);
		end
	endtask

	// Request driver with random idle bursts, none near the end of the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_valid <= 1'b0;
		end else if (element_valid && element_stall) begin
		end else if (send_idle > 0) begin
			element_valid <= 1'b0;
			send_idle <= send_idle - 1;
		end else if (pending_elements.size() > 0) begin
			element_value <= pending_elements.pop_front();
			element_valid <= 1'b1;
			if (pending_elements.size() > 48 && $urandom_range(0, 5) == 0)
				send_idle <= $urandom_range(1, 10);
		end else begin
			element_valid <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_stall <= 1'b0;
		end else if (recv_idle > 0) begin
			inverse_stall <= 1'b1;
			recv_idle <= recv_idle - 1;
		end else begin
			inverse_stall <= 1'b0;
			if (pending_elements.size() > 48 && $urandom_range(0, 3) == 0)
				recv_idle <= $urandom_range(1, 10);
		end
	end

	// Monitor: collects accepted elements and checks accepted results.
	always @(posedge clk) begin
		if (arst_n && element_valid && !element_stall) begin
			loaded_matrix[load_index] = element_value;
			load_index = (load_index + 1) % 16;
			if (load_index == 0) predict_inverse();
		end
		if (arst_n && inverse_valid && !inverse_stall) begin
			mi4_pkg::result_t e;
			if (expected_inverse.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				e = expected_inverse.pop_front();
				if (inverse_value !== e.value)
					report_mismatch($sformatf("inverse_value %h, expected %h",
						inverse_value, e.value));
				if (is_last !== e.last)
					report_mismatch($sformatf("is_last %b, expected %b", is_last, e.last));
				if (singular !== e.sing)
					report_mismatch($sformatf("singular %b, expected %b", singular, e.sing));
				if (saturated !== e.sat)
					report_mismatch($sformatf("saturated %b, expected %b",
						saturated, e.sat));
			end
		end
	end

	task automatic queue_matrix();
		for (int i = 0; i < 16; i++) pending_elements.push_back(mat[i]);
	endtask

	initial begin
		// Identity.
		for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? ONE_Q : '0;
		queue_matrix();
		// Singular: two equal rows of extremes.
		for (int i = 0; i < 16; i++) mat[i] = $urandom();
		for (int i = 0; i < 4; i++) begin
			mat[i] = (i % 2) ? MIN_Q : MAX_Q;
			mat[4 + i] = mat[i];
		end
		queue_matrix();
		// Tiny diagonal saturates both ways; extreme diagonal gives tiny results.
		for (int i = 0; i < 16; i++) mat[i] = '0;
		mat[0] = 32'd1;
		mat[5] = 32'hFFFF_FFFF;
		mat[10] = MAX_Q;
		mat[15] = MIN_Q;
		queue_matrix();
		for (int n = 0; n < MATRICES - 3; n++) begin
			case ($urandom_range(0, 3))
				0: for (int i = 0; i < 16; i++) mat[i] = $urandom();
				1: for (int i = 0; i < 16; i++)
					mat[i] = ((i % 5 == 0) ? ONE_Q : '0)
						+ mi4_pkg::ELEM_W'($urandom_range(0, 32'hFFFF)) - 32'h8000;
				2: begin
					for (int i = 0; i < 16; i++) mat[i] = $urandom();
					for (int i = 0; i < 4; i++) mat[12 + i] = mat[4 * $urandom_range(0, 2) + i];
				end
				default: for (int i = 0; i < 16; i++)
					mat[i] = mi4_pkg::ELEM_W'($urandom_range(0, 16)) - 8;
			endcase
			queue_matrix();
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_elements.size() == 0 && !element_valid);
		wait (expected_inverse.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
